// ----- hw/rtl/ptts_pkg.sv -----
// Package for the periodic timer table scheduler.
// Holds the beat structs, command and result codes, and table sizing.
// No dependencies.
package ptts_pkg;

  localparam int NUM_SLOTS   = 32;
  localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int ENTRY_W     = 6;
  localparam int WAIT_W      = 16;
  localparam int PERIOD_W    = 24;
  localparam int ELAPSED_W   = 16;
  localparam int FIELD_SLOT_W = 5;

  localparam logic [15:0] MAX_WAIT_RESET = 16'd300;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_MAX_WAIT    = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [FIELD_SLOT_W-1:0] slot;
    logic [PERIOD_W-1:0]     period_sec;
    logic [ELAPSED_W-1:0]    elapsed_sec;
  } in_beat_t;

  typedef struct packed {
    logic                    kind;
    logic [FIELD_SLOT_W-1:0] entry_index;
    logic [WAIT_W-1:0]       next_wait_sec;
    logic                    last;
  } out_beat_t;

  typedef struct packed {
    logic                  is_adv;
    logic [SLOT_IDX_W-1:0] slot;
    logic [PERIOD_W-1:0]   period;
    logic [ELAPSED_W-1:0]  elapsed;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

// ----- hw/rtl/ptts_front.sv -----
// Front end: takes input beats, drops out-of-range loads, queues the rest.
// Depends on ptts_pkg.
module ptts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptts_pkg::in_beat_t in_data_i,
  output ptts_pkg::q_head_t  head_o,
  input  logic               pop_i
);
  import ptts_pkg::*;

  q_item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                accept;
  logic                keep;
  logic                push;
  q_item_t             item;

  assign in_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign keep       = (in_data_i.cmd == CMD_ADVANCE) ||
                      ({1'b0, in_data_i.slot} < (FIELD_SLOT_W + 1)'(NUM_SLOTS));
  assign push       = accept && keep;

  always_comb begin
    item.is_adv  = (in_data_i.cmd == CMD_ADVANCE);
    item.slot    = in_data_i.slot[SLOT_IDX_W-1:0];
    item.period  = in_data_i.period_sec;
    item.elapsed = in_data_i.elapsed_sec;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == QCNT_W'(QUEUE_DEPTH) && !pop_i |=> count_q == QCNT_W'(QUEUE_DEPTH))
    else $error("full queue changed without a pop");

endmodule

// ----- hw/rtl/ptts_back.sv -----
// Back end: runs queued loads and advances over the timer tables.
// Holds the period and remaining memories and the output register. Depends on ptts_pkg.
module ptts_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptts_pkg::q_head_t            head_i,
  output logic                         pop_o,
  input  logic [ptts_pkg::ENTRY_W-1:0] entry_count_i,
  input  logic [ptts_pkg::WAIT_W-1:0]  max_wait_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ptts_pkg::out_beat_t          out_data_o
);
  import ptts_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic [PERIOD_W-1:0]  per_mem [NUM_SLOTS];
  logic [PERIOD_W-1:0]  rem_mem [NUM_SLOTS];

  logic                 state_q, state_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     active_q, active_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [WAIT_W-1:0]    wait_q, wait_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic [CNT_W-1:0]     active_sat;
  logic                 out_free;
  logic                 walk_done;
  logic [PERIOD_W-1:0]  rem_rd;
  logic [PERIOD_W-1:0]  per_rd;
  logic                 hit;
  logic [PERIOD_W-1:0]  rem_new;
  logic                 step_en;
  logic                 rep_en;
  logic                 load_en;

  assign active_sat = (entry_count_i > ENTRY_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
                                                             : entry_count_i[CNT_W-1:0];
  assign out_free   = !out_valid_q || out_ready_i;
  assign walk_done  = (idx_q == active_q);
  assign rem_rd     = rem_mem[idx_q[SLOT_IDX_W-1:0]];
  assign per_rd     = per_mem[idx_q[SLOT_IDX_W-1:0]];
  assign hit        = rem_rd <= PERIOD_W'(elapsed_q);
  assign rem_new    = hit ? per_rd : rem_rd - PERIOD_W'(elapsed_q);
  assign step_en    = (state_q == ST_WALK) && !walk_done && (!hit || out_free);
  assign rep_en     = (state_q == ST_WALK) && walk_done && out_free;
  assign pop_o      = (state_q == ST_IDLE) && head_i.valid;
  assign load_en    = pop_o && !head_i.item.is_adv;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    active_d    = active_q;
    elapsed_d   = elapsed_q;
    wait_d      = wait_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o && head_i.item.is_adv) begin
          state_d   = ST_WALK;
          idx_d     = '0;
          active_d  = active_sat;
          elapsed_d = head_i.item.elapsed;
          wait_d    = max_wait_i;
        end
      end
      ST_WALK: begin
        if (step_en) begin
          idx_d = idx_q + 1'b1;
          if (rem_new < PERIOD_W'(wait_q)) begin
            wait_d = rem_new[WAIT_W-1:0];
          end
          if (hit) begin
            out_valid_d       = 1'b1;
            out_d.kind        = KIND_FIRE;
            out_d.entry_index = FIELD_SLOT_W'(idx_q);
            out_d.next_wait_sec = '0;
            out_d.last        = 1'b0;
          end
        end else if (rep_en) begin
          state_d             = ST_IDLE;
          out_valid_d         = 1'b1;
          out_d.kind          = KIND_REPORT;
          out_d.entry_index   = '0;
          out_d.next_wait_sec = wait_q;
          out_d.last          = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    wait_q    <= wait_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      per_mem[head_i.item.slot] <= head_i.item.period;
      rem_mem[head_i.item.slot] <= '0;
    end else if (step_en) begin
      rem_mem[idx_q[SLOT_IDX_W-1:0]] <= rem_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> idx_q <= active_q)
    else $error("walk index past active count");

  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.kind == KIND_REPORT)))
    else $error("last flag disagrees with kind");

  a_fire_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_FIRE |-> CNT_W'(out_q.entry_index) < active_q)
    else $error("fired slot outside active range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(out_q))
    else $error("pending result overwritten");

endmodule

// ----- hw/rtl/periodic_timer_table_scheduler.sv -----
// Periodic timer table scheduler top level: APB registers, front queue, back walker.
// Load: written to the tables when popped from the queue. Advance: queue pop, a walk over
// slots 0 to min(entry_count, NUM_SLOTS) - 1, then the report; output stalls hold both.
// The slot walk sets the rate. Results leave through a registered output.
// Reset clears control state; entry_count resets to 0, max_wait to 300; tables undefined.
// Depends on ptts_pkg, ptts_front and ptts_back.
module periodic_timer_table_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ptts_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ptts_pkg::out_beat_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ptts_pkg::*;

  logic [ENTRY_W-1:0] entry_count_q, entry_count_d;
  logic [WAIT_W-1:0]  max_wait_q, max_wait_d;
  logic               wr_en;
  logic               reg_sel;
  q_head_t            head;
  logic               pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    entry_count_d = entry_count_q;
    max_wait_d    = max_wait_q;
    if (wr_en) begin
      case (reg_sel)
        REG_ENTRY_COUNT: entry_count_d = pwdata[ENTRY_W-1:0];
        REG_MAX_WAIT:    max_wait_d    = pwdata[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENTRY_COUNT: prdata = 32'(entry_count_q);
      REG_MAX_WAIT:    prdata = 32'(max_wait_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      max_wait_q    <= MAX_WAIT_RESET;
    end else begin
      entry_count_q <= entry_count_d;
      max_wait_q    <= max_wait_d;
    end
  end

  ptts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  ptts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .entry_count_i (entry_count_q),
    .max_wait_i    (max_wait_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- sim/tb_periodic_timer_table_scheduler.sv -----
// Testbench for periodic_timer_table_scheduler: a directed table, then random loads and advances
// over several register settings, checked beat by beat against an in-bench timer table model.
// Depends on ptts_pkg and the periodic_timer_table_scheduler RTL.
module tb_periodic_timer_table_scheduler;
  import ptts_pkg::*;

  localparam int LIMIT_CYCLES    = 4_000_000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int TAIL_CYCLES     = 40;
  localparam int PRESSURE_AT     = 60;
  localparam int PRESSURE_HOLD   = 400;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int DIR_ROWS        = 14;

  localparam int PHASE_ENTRIES [NUM_PHASES] = '{32, 63, 1, 17, 33, 0, 32, 2};
  localparam int PHASE_MAX_WAIT [NUM_PHASES] = '{300, 65535, 1, 0, 7, 0, 65535, 300};

  typedef struct packed {
    logic        cfg_en;
    logic        cfg_reg;
    logic [15:0] cfg_val;
    in_beat_t    beat;
    logic        wait_known;
    logic [15:0] wait_exp;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [PERIOD_W-1:0] slot_period    [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_remaining [NUM_SLOTS];
  logic [ENTRY_W-1:0]  cfg_entry_count = '0;
  logic [WAIT_W-1:0]   cfg_max_wait    = MAX_WAIT_RESET;
  out_beat_t           due_results [$];

  int   err_count     = 0;
  int   cycle_count   = 0;
  int   rx_count      = 0;
  int   rx_hold       = 0;
  bit   pressure_done = 1'b0;
  bit   burst_mode    = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, REG_ENTRY_COUNT, 16'd0, '{CMD_ADVANCE, 5'd0, 24'd0, 16'd0}, 1'b1, 16'd300},
    '{1'b0, REG_ENTRY_COUNT, 16'd0, '{CMD_LOAD, 5'd0, 24'd0, 16'd0}, 1'b0, 16'd0},
    '{1'b0, REG_ENTRY_COUNT, 16'd0, '{CMD_LOAD, 5'd1, 24'd8553600, 16'd0}, 1'b0, 16'd0},
    '{1'b0, REG_ENTRY_COUNT, 16'd0, '{CMD_LOAD, 5'd2, 24'd1, 16'd0}, 1'b0, 16'd0},
    '{1'b0, REG_ENTRY_COUNT, 16'd0, '{CMD_LOAD, 5'd31, 24'hFFFFFF, 16'hFFFF}, 1'b0, 16'd0},
    '{1'b1, REG_ENTRY_COUNT, 16'd3, '{CMD_ADVANCE, 5'd0, 24'd0, 16'd0}, 1'b1, 16'd0},
    '{1'b0, REG_ENTRY_COUNT, 16'd0, '{CMD_ADVANCE, 5'd0, 24'd0, 16'hFFFF}, 1'b0, 16'd0},
    '{1'b0, REG_ENTRY_COUNT, 16'd0, '{CMD_LOAD, 5'd0, 24'd5, 16'd0}, 1'b0, 16'd0},
    '{1'b0, REG_ENTRY_COUNT, 16'd0, '{CMD_ADVANCE, 5'd0, 24'd0, 16'd3}, 1'b0, 16'd0},
    '{1'b1, REG_MAX_WAIT, 16'd0, '{CMD_ADVANCE, 5'd0, 24'd0, 16'd0}, 1'b1, 16'd0},
    '{1'b1, REG_MAX_WAIT, 16'hFFFF, '{CMD_ADVANCE, 5'd0, 24'd0, 16'd1}, 1'b0, 16'd0},
    '{1'b1, REG_ENTRY_COUNT, 16'd1, '{CMD_ADVANCE, 5'd0, 24'd0, 16'd2}, 1'b0, 16'd0},
    '{1'b1, REG_ENTRY_COUNT, 16'd0, '{CMD_ADVANCE, 5'd0, 24'd0, 16'hFFFF}, 1'b1, 16'hFFFF},
    '{1'b1, REG_MAX_WAIT, 16'd1, '{CMD_ADVANCE, 5'd0, 24'd0, 16'd0}, 1'b1, 16'd1}
  };

  periodic_timer_table_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2, 3:    return PERIOD_W'($urandom);
      default: return PERIOD_W'($urandom_range(1, 30));
    endcase
  endfunction

  task automatic timer_table_step(input in_beat_t beat);
    int               active;
    logic [WAIT_W-1:0] next_wait;
    if (beat.cmd == CMD_LOAD) begin
      slot_period[beat.slot]    = beat.period_sec;
      slot_remaining[beat.slot] = '0;
    end else begin
      active = (int'(cfg_entry_count) > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_entry_count);
      for (int i = 0; i < active; i++) begin
        if (slot_remaining[i] <= PERIOD_W'(beat.elapsed_sec)) begin
          due_results.push_back('{KIND_FIRE, FIELD_SLOT_W'(i), WAIT_W'(0), 1'b0});
          slot_remaining[i] = slot_period[i];
        end else begin
          slot_remaining[i] = slot_remaining[i] - PERIOD_W'(beat.elapsed_sec);
        end
      end
      next_wait = cfg_max_wait;
      for (int i = 0; i < active; i++) begin
        if (slot_remaining[i] < PERIOD_W'(next_wait)) next_wait = WAIT_W'(slot_remaining[i]);
      end
      due_results.push_back('{KIND_REPORT, FIELD_SLOT_W'(0), next_wait, 1'b1});
    end
  endtask

  task automatic send_beat(input in_beat_t beat, input logic wait_known,
                           input logic [WAIT_W-1:0] wait_exp);
    out_beat_t report;
    int        gap;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    timer_table_step(beat);
    if (wait_known) begin
      report = due_results.pop_back();
      report.next_wait_sec = wait_exp;
      due_results.push_back(report);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_ENTRY_COUNT) cfg_entry_count = value[ENTRY_W-1:0];
    else cfg_max_wait = value[WAIT_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result beat: kind %0d index %0d wait %0d last %0d",
             got.kind, got.entry_index, got.next_wait_sec, got.last);
      err_count++;
    end else begin
      want = due_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("entry_index", want.entry_index, got.entry_index);
      check_field("next_wait_sec", want.next_wait_sec, got.next_wait_sec);
      check_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      check_result(out_data_o);
      rx_count++;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (rx_count == PRESSURE_AT && !pressure_done) begin
      pressure_done = 1'b1;
      rx_hold = PRESSURE_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      rx_hold = pick_gap();
      out_ready_i <= (rx_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_beat_t beat;
    int       entries;
    int       max_wait;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].cfg_en) begin
        settle();
        write_reg(dir_rows[k].cfg_reg, 32'(dir_rows[k].cfg_val));
      end
      send_beat(dir_rows[k].beat, dir_rows[k].wait_known, dir_rows[k].wait_exp);
    end

    for (int s = 0; s < NUM_SLOTS; s++) begin
      beat.cmd         = CMD_LOAD;
      beat.slot        = FIELD_SLOT_W'(s);
      beat.period_sec  = pick_period();
      beat.elapsed_sec = ELAPSED_W'($urandom);
      send_beat(beat, 1'b0, '0);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      burst_mode = (p == 2 || p == 5);
      entries  = (p == 5) ? $urandom_range(0, 63) : PHASE_ENTRIES[p];
      max_wait = (p == 5) ? $urandom_range(1, 65535) : PHASE_MAX_WAIT[p];
      write_reg(REG_ENTRY_COUNT, 32'(entries));
      write_reg(REG_MAX_WAIT, 32'(max_wait));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        beat.cmd        = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_ADVANCE;
        beat.slot       = FIELD_SLOT_W'($urandom);
        beat.period_sec = pick_period();
        case ($urandom_range(0, 9))
          0:       beat.elapsed_sec = ELAPSED_W'($urandom);
          1:       beat.elapsed_sec = '1;
          default: beat.elapsed_sec = ELAPSED_W'($urandom_range(0, 12));
        endcase
        send_beat(beat, 1'b0, '0);
      end
    end

    burst_mode = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
